// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define JTK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent applies in the cycle after the antecedent.
`define JTK_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/jtk_pkg.sv =====
// Shared constants and types for the Jaccard top-k neighbor selector.
`timescale 1ns / 1ps

package jtk_pkg;

  localparam int MAX_NEIGHBORS = 32;
  localparam int INDEX_BITS    = 32;

  localparam int IDX_W      = 32;
  localparam int KEPT_IDX_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int ADDR_W     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W      = $clog2(MAX_NEIGHBORS + 1);

  localparam int K_W = 6;
  localparam logic [K_W-1:0] K_RESET = 6'd30;

  localparam int DEG_W  = 16;
  localparam int SUM_W  = DEG_W + 1;
  localparam int SIM_W  = 17;
  localparam int ALU_W  = SUM_W + 1;
  localparam int QUO_W  = 16;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [SIM_W-1:0] SIM_ONE = 17'h10000;

  localparam logic OP_OFFER    = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  typedef struct packed {
    logic [KEPT_IDX_W-1:0] idx;
    logic [SIM_W-1:0]      sim;
  } entry_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/jtk_alu.sv =====
// Shared compare-subtract unit for the denominator, division steps and similarity compares.
`timescale 1ns / 1ps

module jtk_alu (
  input  jtk_pkg::alu_req_t req,
  output jtk_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.ge   = (req.a >= req.b);
    rsp.diff = req.a - req.b;
  end

endmodule

// ===== hw/rtl/jtk_store.sv =====
// Register file holding kept neighbors, sorted by similarity then arrival.
`timescale 1ns / 1ps

module jtk_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [jtk_pkg::ADDR_W-1:0] wr_addr,
  input  jtk_pkg::entry_t            wr_data,
  input  logic [jtk_pkg::ADDR_W-1:0] rd_addr,
  output jtk_pkg::entry_t            rd_data
);

  jtk_pkg::entry_t entries_r [jtk_pkg::MAX_NEIGHBORS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = entries_r[rd_addr];

endmodule

// ===== hw/rtl/jaccard_topk_neighbor_select.sv =====
// Jaccard top-k neighbor selector: one offer or finalize item at a time.
// An offer computes inter / (deg_q + deg_c - inter) in unsigned Q1.16 with a
// restoring divider that shares one 18-bit compare-subtract unit, one
// quotient bit per cycle, then walks the sorted store from its tail, moving
// one entry per cycle, to place the candidate. An offer is dropped when the
// denominator is zero or negative, when the quotient is zero, or when a full
// store holds no entry weaker than it; a similarity of 1.0 or more saturates
// and skips the divider. A kept offer evicts the weakest entry when the store
// is full, and in_stall stays high after the accepting cycle until the block
// is idle again. A finalize streams one result per cycle out of the store,
// best first, while out_stall is low, then returns to idle. The store needs
// no clearing after reset.
`timescale 1ns / 1ps

module jaccard_topk_neighbor_select (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [jtk_pkg::DEG_W-1:0]  in_intersection_count,
  input  logic [jtk_pkg::DEG_W-1:0]  in_query_degree,
  input  logic [jtk_pkg::DEG_W-1:0]  in_candidate_degree,
  input  logic [jtk_pkg::IDX_W-1:0]  in_candidate_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [jtk_pkg::IDX_W-1:0]  out_neighbor_index,
  output logic [jtk_pkg::SIM_W-1:0]  out_similarity_weight,
  output logic                       out_last_of_run,
  output logic                       out_store_empty,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [jtk_pkg::K_W-1:0]    cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DEN  = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_INS  = 8'b0001_0000,
    S_EVC  = 8'b0010_0000,
    S_SCAN = 8'b0100_0000,
    S_DRN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [jtk_pkg::K_W-1:0]        k_r;
  logic [jtk_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [jtk_pkg::CNT_W-1:0]      keff;
  logic [jtk_pkg::DEG_W-1:0]      inter_r, inter_nxt;
  logic [jtk_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [jtk_pkg::SUM_W-1:0]      denom_r, denom_nxt;
  logic [jtk_pkg::SUM_W-1:0]      rem_r, rem_nxt;
  logic [jtk_pkg::QUO_W-1:0]      quo_r, quo_nxt, quo_new;
  logic [jtk_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [jtk_pkg::SIM_W-1:0]      sim_r, sim_nxt;
  logic [jtk_pkg::KEPT_IDX_W-1:0] cidx_r, cidx_nxt;
  logic [jtk_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  logic                           grow_r, grow_nxt;
  logic [jtk_pkg::ADDR_W-1:0]     didx_r, didx_nxt;
  logic [jtk_pkg::ADDR_W-1:0]     tail_addr;
  logic                           drain_last;

  logic                           out_valid_r, out_valid_nxt;
  logic [jtk_pkg::IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic [jtk_pkg::SIM_W-1:0]      out_sim_r, out_sim_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           out_empty_r, out_empty_nxt;

  jtk_pkg::alu_req_t              alu_req;
  jtk_pkg::alu_rsp_t              alu_rsp;

  logic                           st_we;
  logic [jtk_pkg::ADDR_W-1:0]     st_wr_addr;
  logic [jtk_pkg::ADDR_W-1:0]     st_rd_addr;
  jtk_pkg::entry_t                st_wr_data;
  jtk_pkg::entry_t                st_rd_data;
  jtk_pkg::entry_t                new_entry;

  jtk_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  jtk_store u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid             = out_valid_r;
  assign out_neighbor_index    = out_idx_r;
  assign out_similarity_weight = out_sim_r;
  assign out_last_of_run       = out_last_r;
  assign out_store_empty       = out_empty_r;

  assign new_entry.idx = cidx_r;
  assign new_entry.sim = sim_r;
  assign tail_addr     = jtk_pkg::ADDR_W'(count_r - jtk_pkg::CNT_W'(1));
  assign drain_last    = ((jtk_pkg::CNT_W'(didx_r) + jtk_pkg::CNT_W'(1)) == count_r);
  assign quo_new       = {quo_r[jtk_pkg::QUO_W-2:0], alu_rsp.ge};

  // 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (k_r == '0) begin
      keff = jtk_pkg::CNT_W'(1);
    end else if (32'(k_r) > 32'(jtk_pkg::MAX_NEIGHBORS)) begin
      keff = jtk_pkg::CNT_W'(jtk_pkg::MAX_NEIGHBORS);
    end else begin
      keff = jtk_pkg::CNT_W'(k_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    inter_nxt     = inter_r;
    sum_nxt       = sum_r;
    denom_nxt     = denom_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    sim_nxt       = sim_r;
    cidx_nxt      = cidx_r;
    pos_nxt       = pos_r;
    grow_nxt      = grow_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_sim_nxt   = out_sim_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    alu_req       = '0;
    st_we         = 1'b0;
    st_wr_addr    = pos_r;
    st_wr_data    = new_entry;
    st_rd_addr    = didx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          inter_nxt = in_intersection_count;
          sum_nxt   = jtk_pkg::SUM_W'(in_query_degree) + jtk_pkg::SUM_W'(in_candidate_degree);
          cidx_nxt  = in_candidate_index[jtk_pkg::KEPT_IDX_W-1:0];
          didx_nxt  = '0;
          state_nxt = (in_operation == jtk_pkg::OP_FINALIZE) ? S_DRN : S_DEN;
        end
      end
      S_DEN: begin
        alu_req.a = jtk_pkg::ALU_W'(sum_r);
        alu_req.b = jtk_pkg::ALU_W'(inter_r);
        denom_nxt = alu_rsp.diff[jtk_pkg::SUM_W-1:0];
        state_nxt = (!alu_rsp.ge || alu_rsp.diff == '0) ? S_IDLE : S_CHK;
      end
      S_CHK: begin
        // inter >= denom saturates at 1.0
        alu_req.a = jtk_pkg::ALU_W'(inter_r);
        alu_req.b = jtk_pkg::ALU_W'(denom_r);
        rem_nxt   = jtk_pkg::SUM_W'(inter_r);
        quo_nxt   = '0;
        step_nxt  = '0;
        sim_nxt   = jtk_pkg::SIM_ONE;
        state_nxt = alu_rsp.ge ? S_INS : S_DIV;
      end
      S_DIV: begin
        alu_req.a = {rem_r, 1'b0};
        alu_req.b = jtk_pkg::ALU_W'(denom_r);
        rem_nxt   = alu_rsp.ge ? alu_rsp.diff[jtk_pkg::SUM_W-1:0]
                               : alu_req.a[jtk_pkg::SUM_W-1:0];
        quo_nxt   = quo_new;
        step_nxt  = step_r + jtk_pkg::STEP_W'(1);
        if (step_r == jtk_pkg::STEP_W'(jtk_pkg::QUO_W - 1)) begin
          sim_nxt   = jtk_pkg::SIM_W'(quo_new);
          state_nxt = (quo_new == '0) ? S_IDLE : S_INS;
        end
      end
      S_INS: begin
        if (count_r < keff) begin
          pos_nxt   = count_r[jtk_pkg::ADDR_W-1:0];
          grow_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EVC;
        end
      end
      S_EVC: begin
        // tail is the weakest, latest-arrived entry
        st_rd_addr = tail_addr;
        alu_req.a  = jtk_pkg::ALU_W'(st_rd_data.sim);
        alu_req.b  = jtk_pkg::ALU_W'(sim_r);
        if (alu_rsp.ge) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = tail_addr;
          grow_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        st_rd_addr = pos_r - jtk_pkg::ADDR_W'(1);
        alu_req.a  = jtk_pkg::ALU_W'(st_rd_data.sim);
        alu_req.b  = jtk_pkg::ALU_W'(sim_r);
        st_we      = 1'b1;
        if (pos_r == '0 || alu_rsp.ge) begin
          st_wr_data = new_entry;
          if (grow_r) begin
            count_nxt = count_r + jtk_pkg::CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end else begin
          st_wr_data = st_rd_data;
          pos_nxt    = pos_r - jtk_pkg::ADDR_W'(1);
        end
      end
      S_DRN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_idx_nxt   = '0;
            out_sim_nxt   = '0;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            out_idx_nxt   = jtk_pkg::IDX_W'(st_rd_data.idx);
            out_sim_nxt   = st_rd_data.sim;
            out_last_nxt  = drain_last;
            out_empty_nxt = 1'b0;
            didx_nxt      = didx_r + jtk_pkg::ADDR_W'(1);
            if (drain_last) begin
              count_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= jtk_pkg::K_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        k_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    inter_r     <= inter_nxt;
    sum_r       <= sum_nxt;
    denom_r     <= denom_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    sim_r       <= sim_nxt;
    cidx_r      <= cidx_nxt;
    pos_r       <= pos_nxt;
    grow_r      <= grow_nxt;
    didx_r      <= didx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_sim_r   <= out_sim_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

// ===== hw/rtl/jtk_checker.sv =====
// Port-level checker for the Jaccard top-k neighbor selector, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jtk_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [jtk_pkg::IDX_W-1:0]  out_neighbor_index,
  input logic [jtk_pkg::SIM_W-1:0]  out_similarity_weight,
  input logic                       out_last_of_run,
  input logic                       out_store_empty
);

  logic [jtk_pkg::IDX_W+jtk_pkg::SIM_W+1:0] out_payload;
  logic                                     empty_fields_ok;
  logic                                     sim_range_ok;

  assign out_payload = {out_neighbor_index, out_similarity_weight, out_last_of_run,
                        out_store_empty};

  assign empty_fields_ok = !(out_valid && out_store_empty) ||
                           (out_neighbor_index == '0 && out_similarity_weight == '0 &&
                            !out_last_of_run);

  assign sim_range_ok = !(out_valid && !out_store_empty) ||
                        (out_similarity_weight != '0 &&
                         out_similarity_weight <= jtk_pkg::SIM_ONE);

  // stalled result item holds
  `JTK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload), "stalled result changed")

  // an accepted item always keeps the block busy for the next cycle
  `JTK_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken back to back")

  `JTK_ASSERT(a_empty_fields, empty_fields_ok, "empty result has nonzero fields")

  `JTK_ASSERT(a_sim_range, sim_range_ok, "kept similarity out of range")

endmodule

bind jaccard_topk_neighbor_select jtk_checker u_jtk_checker (.*);

// ===== test/tb_jaccard_topk_neighbor_select.sv =====
// Self-checking testbench for the Jaccard top-k neighbor selector.
`timescale 1ns / 1ps

module tb_jaccard_topk_neighbor_select;
  import jtk_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [SIM_W-1:0] sim;
  } kept_pair_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [SIM_W-1:0] sim;
    logic             last;
    logic             empty;
  } neighbor_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_operation = OP_OFFER;
  logic [DEG_W-1:0] in_intersection_count = '0;
  logic [DEG_W-1:0] in_query_degree = '0;
  logic [DEG_W-1:0] in_candidate_degree = '0;
  logic [IDX_W-1:0] in_candidate_index = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_neighbor_index;
  logic [SIM_W-1:0] out_similarity_weight;
  logic             out_last_of_run;
  logic             out_store_empty;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [K_W-1:0]   cfg_data = '0;

  kept_pair_t     kept_store[$];
  neighbor_t      pending_neighbors[$];
  logic [K_W-1:0] k_setting = K_RESET;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_len;
  int             held_cycles;
  int             mismatches;

  jaccard_topk_neighbor_select dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #9_600_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_len != 0) begin
      held_cycles = hold_len;
      hold_len = 0;
    end
    if (held_cycles > 0) begin
      held_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    neighbor_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_neighbors.size() == 0) begin
        $error("result with none pending: neighbor_index %0h", out_neighbor_index);
        mismatches++;
      end else begin
        want = pending_neighbors.pop_front();
        check_field("neighbor_index", want.idx, out_neighbor_index);
        check_field("similarity_weight", IDX_W'(want.sim), IDX_W'(out_similarity_weight));
        check_field("last_of_run", IDX_W'(want.last), IDX_W'(out_last_of_run));
        check_field("store_empty", IDX_W'(want.empty), IDX_W'(out_store_empty));
      end
    end
  end

  // Q1.16 Jaccard weight, truncated, saturating at 1.0; zero means discard
  function automatic logic [SIM_W-1:0] jaccard_weight(logic [DEG_W-1:0] inter,
                                                      logic [DEG_W-1:0] qd,
                                                      logic [DEG_W-1:0] cd);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] denom;
    logic [32:0]      quot;
    sum = {1'b0, qd} + {1'b0, cd};
    if ({1'b0, inter} >= sum) return '0;
    denom = sum - {1'b0, inter};
    quot = {1'b0, inter, 16'h0} / {16'h0, denom};
    if (quot > 33'(SIM_ONE)) quot = 33'(SIM_ONE);
    return quot[SIM_W-1:0];
  endfunction

  function automatic void keep_candidate(logic [SIM_W-1:0] sim, logic [IDX_W-1:0] idx);
    int         k;
    int         weakest;
    kept_pair_t cand;
    k = (k_setting == 0) ? 1 :
        (int'(k_setting) > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(k_setting);
    cand.idx = idx;
    cand.sim = sim;
    if (sim == 0) return;
    if (kept_store.size() < k) begin
      kept_store.insert(kept_store.size(), cand);
      return;
    end
    // weakest entry; on equal weights the latest arrival goes
    weakest = 0;
    for (int i = 1; i < kept_store.size(); i++) begin
      if (kept_store[i].sim <= kept_store[weakest].sim) weakest = i;
    end
    if (sim <= kept_store[weakest].sim) return;
    kept_store.delete(weakest);
    kept_store.insert(kept_store.size(), cand);
  endfunction

  function automatic void drain_store();
    kept_pair_t ranked[$];
    neighbor_t  r;
    int         j;
    if (kept_store.size() == 0) begin
      r = '{idx: '0, sim: '0, last: 1'b0, empty: 1'b1};
      pending_neighbors.insert(pending_neighbors.size(), r);
      return;
    end
    // stable: descending weight, ties in arrival order
    foreach (kept_store[i]) begin
      j = ranked.size();
      while (j > 0 && ranked[j-1].sim < kept_store[i].sim) j--;
      ranked.insert(j, kept_store[i]);
    end
    foreach (ranked[i]) begin
      r.idx = ranked[i].idx;
      r.sim = ranked[i].sim;
      r.last = (i == ranked.size() - 1);
      r.empty = 1'b0;
      pending_neighbors.insert(pending_neighbors.size(), r);
    end
    kept_store.delete();
  endfunction

  task automatic send_item(input logic op, input logic [DEG_W-1:0] inter,
                           input logic [DEG_W-1:0] qd, input logic [DEG_W-1:0] cd,
                           input logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_intersection_count <= inter;
    in_query_degree <= qd;
    in_candidate_degree <= cd;
    in_candidate_index <= idx;
    do @(posedge clk); while (in_stall);
    if (op == OP_FINALIZE) drain_store();
    else keep_candidate(jaccard_weight(inter, qd, cd), idx);
  endtask

  // offers may still be in flight when the last result arrives
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_neighbors.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_k(logic [K_W-1:0] k);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    k_setting = k;
  endtask

  task automatic send_random_offer();
    logic [DEG_W-1:0] inter;
    logic [DEG_W-1:0] qd;
    logic [DEG_W-1:0] cd;
    int               mode;
    mode = $urandom_range(99);
    if (mode < 65) begin
      qd = DEG_W'($urandom_range(1, 48));
      cd = DEG_W'($urandom_range(1, 48));
      inter = DEG_W'($urandom_range(1, (qd < cd) ? qd : cd));
    end else if (mode < 80) begin
      qd = DEG_W'($urandom);
      cd = DEG_W'($urandom);
      inter = DEG_W'($urandom_range(0, (qd < cd) ? qd : cd));
    end else if (mode < 90) begin
      inter = DEG_W'($urandom);
      qd = DEG_W'($urandom);
      cd = DEG_W'($urandom);
    end else begin
      inter = DEG_W'($urandom_range(1, 16));
      qd = DEG_W'($urandom_range(0, inter));
      cd = DEG_W'($urandom_range(0, inter));
    end
    send_item(OP_OFFER, inter, qd, cd, $urandom);
  endtask

  task automatic send_random_finalize();
    send_item(OP_FINALIZE, DEG_W'($urandom), DEG_W'($urandom), DEG_W'($urandom), $urandom);
  endtask

  task automatic test_empty_finalize();
    send_item(OP_FINALIZE, '1, '1, '1, '1);
  endtask

  task automatic test_special_cases();
    send_item(OP_OFFER, 16'd0, 16'd0, 16'd0, 32'd5);
    send_item(OP_OFFER, 16'd10, 16'd3, 16'd4, 32'd6);
    send_item(OP_OFFER, 16'd1, 16'hFFFF, 16'hFFFF, 32'd7);
    send_item(OP_OFFER, 16'd1, 16'hFFFF, 16'd1, 32'hFFFF_FFFF);
    send_item(OP_OFFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
    send_item(OP_OFFER, 16'd50000, 16'd40000, 16'd40000, 32'hA5A5_5A5A);
    send_item(OP_OFFER, 16'd3, 16'd5, 16'd4, 32'h5A5A_A5A5);
    send_item(OP_OFFER, 16'd3, 16'd5, 16'd4, 32'd1);
    send_item(OP_FINALIZE, 16'd0, 16'd0, 16'd0, 32'd0);
  endtask

  task automatic test_eviction_tie();
    write_k(6'd2);
    send_item(OP_OFFER, 16'd1, 16'd2, 16'd2, 32'd100);
    send_item(OP_OFFER, 16'd1, 16'd2, 16'd2, 32'd101);
    send_item(OP_OFFER, 16'd1, 16'd2, 16'd2, 32'd102);
    send_item(OP_OFFER, 16'd1, 16'd1, 16'd2, 32'd103);
    send_item(OP_FINALIZE, 16'd0, 16'd0, 16'd0, 32'd0);
  endtask

  task automatic test_k_lowered();
    write_k(6'd4);
    send_item(OP_OFFER, 16'd1, 16'd4, 16'd4, 32'd200);
    send_item(OP_OFFER, 16'd2, 16'd4, 16'd4, 32'd201);
    send_item(OP_OFFER, 16'd3, 16'd4, 16'd4, 32'd202);
    send_item(OP_OFFER, 16'd1, 16'd8, 16'd8, 32'd203);
    write_k(6'd1);
    send_item(OP_OFFER, 16'd4, 16'd4, 16'd4, 32'd204);
    send_item(OP_OFFER, 16'd1, 16'd16, 16'd16, 32'd205);
    send_item(OP_FINALIZE, 16'd0, 16'd0, 16'd0, 32'd0);
  endtask

  // full store drained into a held receiver while offers keep coming
  task automatic test_backpressure();
    logic [DEG_W-1:0] inter;
    write_k(6'd32);
    repeat (32) begin
      inter = DEG_W'($urandom_range(1, 20));
      send_item(OP_OFFER, inter, DEG_W'($urandom_range(inter, 40)),
                DEG_W'($urandom_range(inter, 40)), $urandom);
    end
    hold_len = 400;
    send_random_finalize();
    repeat (12) send_random_offer();
    send_random_finalize();
    settle();
  endtask

  task automatic test_random_rows(int n_items, logic [K_W-1:0] first_k);
    int sent;
    int offers;
    write_k(first_k);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_k(K_W'($urandom_range(0, 63)));
      offers = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 36);
      if (offers > n_items - sent - 1) offers = n_items - sent - 1;
      repeat (offers) send_random_offer();
      send_random_finalize();
      sent += offers + 1;
    end
  endtask

  initial begin
    send_idle_pct = 29;
    recv_stall_pct = 54;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_finalize();
    test_special_cases();
    test_eviction_tie();
    test_k_lowered();
    test_backpressure();
    test_random_rows(84, 6'd63);
    send_idle_pct = 54;
    recv_stall_pct = 29;
    test_random_rows(84, 6'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_rows(84, 6'd32);
    settle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
